/* rtl/pfau_pkg.sv */
package pfau_pkg;

   localparam int OP_W   = 3;
   localparam int RES_W  = 30;
   localparam int EXP_W  = 31;
   localparam int PROD_W = 2 * RES_W;
   localparam int MU_W   = RES_W + 1;
   localparam int REM_W  = RES_W + 2;

   localparam int REQ_DATA_W = 96;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 32;

   localparam logic [RES_W-1:0] MODULUS = RES_W'(1000000009);

   localparam logic [63:0] MU_FULL = (64'd1 << PROD_W) / {{(64-RES_W){1'b0}}, MODULUS};
   localparam logic [MU_W-1:0] MU = MU_FULL[MU_W-1:0];

   localparam logic [EXP_W-1:0] INV_EXP = {1'b0, MODULUS - RES_W'(2)};
   localparam logic [RES_W-1:0] ONE     = RES_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_POW = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      MSEL_SQSQ  = 2'd0,
      MSEL_ACCSQ = 2'd1,
      MSEL_AACC  = 2'd2
   } mul_sel_type;

   typedef enum logic [1:0] {
      RSEL_ADD  = 2'd0,
      RSEL_SUB  = 2'd1,
      RSEL_ACC  = 2'd2,
      RSEL_ZERO = 2'd3
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        prep;
      logic        issue;
      mul_sel_type mul_sel;
      logic        shift;
      logic        finish;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            e_zero;
      logic            e_lsb;
      logic            mul_busy;
      logic            out_free;
   } status_type;

endpackage

/* rtl/prime_field_arithmetic_unit.sv */
// Arithmetic over the prime field of modulus 1000000009, one transaction at a time.
// Request channel req_*: opcode in req_tuser, residues and exponent in req_tdata.
// Response channel rsp_*: one residue per request, in request order.
// Operands at or above the modulus are reduced first. Divide by zero gives 0,
// any base to the power 0 gives 1, unused opcodes give 0.
// Add, subtract and unused opcodes finish without the multiplier; multiply issues one
// product; divide raises the divisor to the power modulus-2 for its inverse, then
// issues one product; power works through the exponent bits up to the highest set bit.
// All products go through one shared 4-stage Barrett modular multiplier; each
// exponent bit issues a squaring and, when the bit is set, a product, then
// waits for the multiplier to drain.
// A new request is taken once the previous one has moved into the response
// register, so the next transaction runs while a response waits; if the
// receiver keeps stalling, the finished result holds until the register frees.
// Reset clears the controller, the multiplier valid pipeline and the response valid; data registers are not reset.
module prime_field_arithmetic_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // operand_a [29:0], operand_b [59:30], exponent [90:60], zero [95:91]
   input  logic [pfau_pkg::REQ_DATA_W-1:0]    req_tdata,
   // opcode [2:0]
   input  logic [pfau_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // result [29:0], zero [31:30]
   output logic [pfau_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import pfau_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [RES_W-1:0] result;

   pfau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pfau_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .opcode     (req_tuser[OP_W-1:0]),
      .operand_a  (req_tdata[RES_W-1:0]),
      .operand_b  (req_tdata[2*RES_W-1:RES_W]),
      .exponent   (req_tdata[2*RES_W+EXP_W-1:2*RES_W]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {{(RSP_DATA_W-RES_W){1'b0}}, result};

endmodule

/* rtl/pfau_modmul.sv */
module pfau_modmul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_dest,
   input  logic [pfau_pkg::RES_W-1:0]  x,
   input  logic [pfau_pkg::RES_W-1:0]  y,
   output logic                        out_valid,
   output logic                        out_dest,
   output logic [pfau_pkg::RES_W-1:0]  out_value,
   output logic                        busy
);
   import pfau_pkg::*;

   logic [3:0]            valid_ff, valid_in;
   logic [3:0]            dest_ff, dest_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [2*MU_W-1:0]     q2_ff, q2_in;
   logic [REM_W-1:0]      plo_ff, plo_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [RES_W-1:0]      out_ff, out_in;
   logic [MU_W-1:0]       q3;
   logic [REM_W-1:0]      qm;
   logic [REM_W-1:0]      rem_m1, rem_m2;

   always_comb begin
      valid_in = {valid_ff[2:0], in_valid};
      dest_in  = {dest_ff[2:0], in_dest};
      prod_in  = PROD_W'(x) * PROD_W'(y);
      q2_in    = (2*MU_W)'(prod_ff[PROD_W-1:RES_W-1]) * (2*MU_W)'(MU);
      plo_in   = prod_ff[REM_W-1:0];
      q3       = q2_ff[2*MU_W-1:MU_W];
      qm       = REM_W'(q3) * REM_W'(MODULUS);
      rem_in   = plo_ff - qm;
      rem_m1   = rem_ff - REM_W'(MODULUS);
      rem_m2   = rem_ff - (REM_W'(MODULUS) << 1);
      priority if (rem_ff >= (REM_W'(MODULUS) << 1)) begin
         out_in = rem_m2[RES_W-1:0];
      end else if (rem_ff >= REM_W'(MODULUS)) begin
         out_in = rem_m1[RES_W-1:0];
      end else begin
         out_in = rem_ff[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dest_ff <= dest_in;
      prod_ff <= prod_in;
      q2_ff   <= q2_in;
      plo_ff  <= plo_in;
      rem_ff  <= rem_in;
      out_ff  <= out_in;
   end

   assign out_valid = valid_ff[3];
   assign out_dest  = dest_ff[3];
   assign out_value = out_ff;
   assign busy      = |valid_ff;

endmodule

/* rtl/pfau_datapath.sv */
module pfau_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [pfau_pkg::OP_W-1:0]    opcode,
   input  logic [pfau_pkg::RES_W-1:0]   operand_a,
   input  logic [pfau_pkg::RES_W-1:0]   operand_b,
   input  logic [pfau_pkg::EXP_W-1:0]   exponent,
   input  pfau_pkg::cmd_type            cmd,
   output pfau_pkg::status_type         status,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [pfau_pkg::RES_W-1:0]   result
);
   import pfau_pkg::*;

   logic [OP_W-1:0]  op_ff, op_in;
   logic [RES_W-1:0] raw_a_ff, raw_a_in;
   logic [RES_W-1:0] raw_b_ff, raw_b_in;
   logic [EXP_W-1:0] raw_e_ff, raw_e_in;
   logic [RES_W-1:0] a_ff, a_in;
   logic [RES_W-1:0] b_ff, b_in;
   logic [EXP_W-1:0] e_ff, e_in;
   logic [RES_W-1:0] acc_ff, acc_in;
   logic [RES_W-1:0] sq_ff, sq_in;
   logic [RES_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [RES_W-1:0] a_red, b_red;
   logic [RES_W-1:0] mul_x, mul_y;
   logic             mul_dest;
   logic             mul_out_valid, mul_out_dest, mul_busy;
   logic [RES_W-1:0] mul_out;
   logic [RES_W:0]   sum;
   logic [RES_W:0]   sum_m;
   logic [RES_W-1:0] add_res, sub_res;

   function automatic logic [RES_W-1:0] reduce(input logic [RES_W-1:0] v);
      reduce = (v >= MODULUS) ? (v - MODULUS) : v;
   endfunction

   always_comb begin
      a_red = reduce(raw_a_ff);
      b_red = reduce(raw_b_ff);

      unique case (cmd.mul_sel)
         MSEL_SQSQ: begin
            mul_x = sq_ff;
            mul_y = sq_ff;
         end
         MSEL_ACCSQ: begin
            mul_x = acc_ff;
            mul_y = sq_ff;
         end
         MSEL_AACC: begin
            mul_x = a_ff;
            mul_y = acc_ff;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
      mul_dest = (cmd.mul_sel != MSEL_SQSQ);

      sum     = {1'b0, a_ff} + {1'b0, b_ff};
      sum_m   = sum - {1'b0, MODULUS};
      add_res = (sum >= {1'b0, MODULUS}) ? sum_m[RES_W-1:0] : sum[RES_W-1:0];
      sub_res = (a_ff >= b_ff) ? (a_ff - b_ff) : (a_ff + (MODULUS - b_ff));

      op_in    = op_ff;
      raw_a_in = raw_a_ff;
      raw_b_in = raw_b_ff;
      raw_e_in = raw_e_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      e_in     = e_ff;
      acc_in   = acc_ff;
      sq_in    = sq_ff;

      if (cmd.load) begin
         op_in    = opcode;
         raw_a_in = operand_a;
         raw_b_in = operand_b;
         raw_e_in = exponent;
      end

      if (cmd.prep) begin
         a_in   = a_red;
         b_in   = b_red;
         acc_in = (op_ff == OP_MUL) ? b_red : ONE;
         sq_in  = (op_ff == OP_POW) ? a_red : b_red;
         priority if (op_ff == OP_POW) begin
            e_in = raw_e_ff;
         end else if (op_ff == OP_DIV) begin
            e_in = INV_EXP;
         end else begin
            e_in = '0;
         end
      end

      if (cmd.shift) begin
         e_in = e_ff >> 1;
      end

      if (mul_out_valid) begin
         if (mul_out_dest) begin
            acc_in = mul_out;
         end else begin
            sq_in = mul_out;
         end
      end

      unique case (cmd.res_sel)
         RSEL_ADD:  rsp_data_in = add_res;
         RSEL_SUB:  rsp_data_in = sub_res;
         RSEL_ACC:  rsp_data_in = acc_ff;
         RSEL_ZERO: rsp_data_in = '0;
      endcase
      if (!cmd.finish) begin
         rsp_data_in = rsp_data_ff;
      end

      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   pfau_modmul u_modmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd.issue),
      .in_dest   (mul_dest),
      .x         (mul_x),
      .y         (mul_y),
      .out_valid (mul_out_valid),
      .out_dest  (mul_out_dest),
      .out_value (mul_out),
      .busy      (mul_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      raw_a_ff    <= raw_a_in;
      raw_b_ff    <= raw_b_in;
      raw_e_ff    <= raw_e_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      e_ff        <= e_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      status.op       = op_ff;
      status.e_zero   = (e_ff == '0);
      status.e_lsb    = e_ff[0];
      status.mul_busy = mul_busy;
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign result     = rsp_data_ff;

endmodule

/* rtl/pfau_ctrl.sv */
module pfau_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  pfau_pkg::status_type  status,
   output pfau_pkg::cmd_type     cmd
);
   import pfau_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_PREP   = 8'b0000_0010,
      S_BIT    = 8'b0000_0100,
      S_MULACC = 8'b0000_1000,
      S_WAIT   = 8'b0001_0000,
      S_FINAL  = 8'b0010_0000,
      S_FWAIT  = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      op_is_prod;

   always_comb begin
      op_is_prod = (status.op == OP_MUL) || (status.op == OP_DIV);

      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.prep    = 1'b0;
      cmd.issue   = 1'b0;
      cmd.mul_sel = MSEL_SQSQ;
      cmd.shift   = 1'b0;
      cmd.finish  = 1'b0;

      priority if (status.op == OP_ADD) begin
         cmd.res_sel = RSEL_ADD;
      end else if (status.op == OP_SUB) begin
         cmd.res_sel = RSEL_SUB;
      end else if (op_is_prod || (status.op == OP_POW)) begin
         cmd.res_sel = RSEL_ACC;
      end else begin
         cmd.res_sel = RSEL_ZERO;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_BIT;
         end
         S_BIT: begin
            if (status.e_zero) begin
               state_in = op_is_prod ? S_FINAL : S_FINISH;
            end else begin
               cmd.issue   = 1'b1;
               cmd.mul_sel = MSEL_SQSQ;
               state_in    = S_MULACC;
            end
         end
         S_MULACC: begin
            cmd.issue   = status.e_lsb;
            cmd.mul_sel = MSEL_ACCSQ;
            cmd.shift   = 1'b1;
            state_in    = S_WAIT;
         end
         S_WAIT: begin
            if (!status.mul_busy) begin
               state_in = S_BIT;
            end
         end
         S_FINAL: begin
            cmd.issue   = 1'b1;
            cmd.mul_sel = MSEL_AACC;
            state_in    = S_FWAIT;
         end
         S_FWAIT: begin
            if (!status.mul_busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/pfau_checker.sv */
module pfau_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [pfau_pkg::REQ_DATA_W-1:0]    req_tdata,
   input logic [pfau_pkg::REQ_USER_W-1:0]    req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [pfau_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import pfau_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a transaction is in flight");

   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RES_W-1:0] < MODULUS)
                     && (rsp_tdata[RSP_DATA_W-1:RES_W] == '0))
      else $error("response not a reduced residue");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not clear the unit");

endmodule

bind prime_field_arithmetic_unit pfau_checker u_pfau_checker (.*);

/* dv/prime_field_arithmetic_unit_tb.sv */
module prime_field_arithmetic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfau_pkg::*;

   localparam longint unsigned PRIME = 64'd1000000009;
   localparam logic [RES_W-1:0] RESIDUE_MAX = RES_W'(PRIME - 1);
   localparam logic [RES_W-1:0] RAW_MAX     = '1;
   localparam logic [EXP_W-1:0] EXP_MAX     = '1;
   localparam logic [OP_W-1:0]  OP_RSVD5    = 3'd5;
   localparam logic [OP_W-1:0]  OP_RSVD6    = 3'd6;
   localparam logic [OP_W-1:0]  OP_RSVD7    = 3'd7;
   localparam int RANDOM_ITEMS = 1500;
   localparam int DRAIN_CYCLES = 250;
   localparam int PRINT_CAP    = 40;

   typedef struct {
      logic             drain;
      logic [OP_W-1:0]  op;
      logic [RES_W-1:0] a;
      logic [RES_W-1:0] b;
      logic [EXP_W-1:0] e;
   } field_op_type;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [RES_W-1:0] value;
   } residue_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   field_op_type pending_ops[$];
   residue_type  expected_residues[$];
   bit        req_taken = 1'b0;
   int        total_items = 0;
   int        accepted_items = 0;
   int        drain_pauses = 0;
   int        mismatches = 0;
   int        op_count[8];

   prime_field_arithmetic_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", expected_residues.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic longint unsigned field_power(longint unsigned base, longint unsigned ex);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1 % PRIME;
      sq  = base % PRIME;
      while (ex != 0) begin
         if ((ex & 1) != 0) acc = (acc * sq) % PRIME;
         sq = (sq * sq) % PRIME;
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic logic [RES_W-1:0] field_result(logic [OP_W-1:0] op, logic [RES_W-1:0] a,
                                                     logic [RES_W-1:0] b, logic [EXP_W-1:0] e);
      longint unsigned ra;
      longint unsigned rb;
      longint unsigned r;
      ra = longint'(a) % PRIME;
      rb = longint'(b) % PRIME;
      case (op)
         OP_ADD: r = (ra + rb) % PRIME;
         OP_SUB: r = (ra + PRIME - rb) % PRIME;
         OP_MUL: r = (ra * rb) % PRIME;
         OP_DIV: r = (ra * field_power(rb, PRIME - 2)) % PRIME;
         OP_POW: r = field_power(ra, longint'(e));
         default: r = 0;
      endcase
      return RES_W'(r);
   endfunction

   function automatic int send_idle_pct();
      if (accepted_items * 3 < total_items) return 30;
      if (accepted_items * 3 < total_items * 2) return 47;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (accepted_items * 3 < total_items) return 47;
      if (accepted_items * 3 < total_items * 2) return 30;
      return 0;
   endfunction

   function automatic logic [RES_W-1:0] random_operand();
      case ($urandom_range(9))
         0: return '0;
         1: return ONE;
         2: return RESIDUE_MAX;
         3: return RES_W'($urandom_range(int'(RAW_MAX), int'(PRIME)));
         default: return RES_W'($urandom_range(int'(RESIDUE_MAX)));
      endcase
   endfunction

   function automatic logic [EXP_W-1:0] random_exponent();
      case ($urandom_range(7))
         0: return '0;
         1: return EXP_W'($urandom_range(15));
         2: return EXP_MAX;
         default: return EXP_W'($urandom());
      endcase
   endfunction

   task automatic queue_op(logic drain, logic [OP_W-1:0] op, logic [RES_W-1:0] a,
                           logic [RES_W-1:0] b, logic [EXP_W-1:0] e);
      field_op_type item;
      item.drain = drain;
      item.op    = op;
      item.a     = a;
      item.b     = b;
      item.e     = e;
      pending_ops.push_back(item);
   endtask

   task automatic report_mismatch(string what, logic [OP_W-1:0] op, logic [RES_W-1:0] want,
                                  logic [RES_W-1:0] got);
      if (mismatches < PRINT_CAP)
         $display("%t mismatch %s: op %0d expected %0d got %0d", $realtime, what, op, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      residue_type exp_item;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            exp_item.op    = req_tuser;
            exp_item.value = field_result(req_tuser, req_tdata[RES_W-1:0],
                                          req_tdata[2*RES_W-1:RES_W],
                                          req_tdata[2*RES_W+EXP_W-1:2*RES_W]);
            expected_residues.push_back(exp_item);
            op_count[req_tuser]++;
            accepted_items++;
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_residues.size() == 0) begin
               report_mismatch("unrequested result", '0, '0, rsp_tdata[RES_W-1:0]);
            end else begin
               exp_item = expected_residues.pop_front();
               if (rsp_tdata[RES_W-1:0] !== exp_item.value)
                  report_mismatch("result", exp_item.op, exp_item.value, rsp_tdata[RES_W-1:0]);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_taken) begin
            void'(pending_ops.pop_front());
            req_taken = 1'b0;
            if (pending_ops.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_ops[0].drain && expected_residues.size() != 0) begin
               req_tvalid <= 1'b0;
            end else if ($urandom_range(99) < send_idle_pct()) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= {5'b0, pending_ops[0].e, pending_ops[0].b, pending_ops[0].a};
               req_tuser  <= pending_ops[0].op;
            end
         end else if (!req_tvalid) begin
            if (pending_ops.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_ops[0].drain && expected_residues.size() != 0) begin
               req_tvalid <= 1'b0;
            end else if ($urandom_range(99) < send_idle_pct()) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= {5'b0, pending_ops[0].e, pending_ops[0].b, pending_ops[0].a};
               req_tuser  <= pending_ops[0].op;
            end
         end
      end
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct());
   end

   initial begin
      logic [OP_W-1:0] op;
      int              pick;
      int              i;

      queue_op(1'b0, OP_ADD, RESIDUE_MAX, RESIDUE_MAX, '0);
      queue_op(1'b0, OP_ADD, '0, '0, EXP_MAX);
      queue_op(1'b0, OP_ADD, RAW_MAX, RAW_MAX, '0);
      queue_op(1'b0, OP_SUB, '0, RESIDUE_MAX, '0);
      queue_op(1'b0, OP_SUB, RESIDUE_MAX, '0, '0);
      queue_op(1'b0, OP_SUB, '0, RAW_MAX, EXP_MAX);
      queue_op(1'b0, OP_MUL, RESIDUE_MAX, RESIDUE_MAX, '0);
      queue_op(1'b0, OP_MUL, RAW_MAX, RAW_MAX, '0);
      queue_op(1'b0, OP_MUL, '0, RESIDUE_MAX, '0);
      queue_op(1'b0, OP_DIV, RESIDUE_MAX, '0, '0);
      queue_op(1'b0, OP_DIV, ONE, ONE, '0);
      queue_op(1'b0, OP_DIV, RESIDUE_MAX, RESIDUE_MAX, EXP_MAX);
      queue_op(1'b0, OP_DIV, RES_W'(12345), RES_W'(PRIME), '0);
      queue_op(1'b0, OP_DIV, RES_W'(777), RAW_MAX, '0);
      queue_op(1'b0, OP_POW, '0, '0, '0);
      queue_op(1'b0, OP_POW, RESIDUE_MAX, RAW_MAX, '0);
      queue_op(1'b0, OP_POW, '0, '0, EXP_W'(5));
      queue_op(1'b0, OP_POW, RES_W'(2), '0, EXP_MAX);
      queue_op(1'b0, OP_POW, RESIDUE_MAX, '0, EXP_MAX);
      queue_op(1'b0, OP_POW, RAW_MAX, '0, EXP_W'(32'h5555_5555));
      queue_op(1'b0, OP_POW, ONE, '0, EXP_W'(32'h2AAA_AAAA));
      queue_op(1'b0, OP_RSVD5, RAW_MAX, RAW_MAX, EXP_MAX);
      queue_op(1'b0, OP_RSVD6, RESIDUE_MAX, ONE, EXP_MAX);
      queue_op(1'b0, OP_RSVD7, RAW_MAX, RAW_MAX, EXP_MAX);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(99);
         if (pick < 15) op = OP_ADD;
         else if (pick < 30) op = OP_SUB;
         else if (pick < 50) op = OP_MUL;
         else if (pick < 70) op = OP_DIV;
         else if (pick < 94) op = OP_POW;
         else if (pick < 96) op = OP_RSVD5;
         else if (pick < 98) op = OP_RSVD6;
         else op = OP_RSVD7;
         if (i % 300 == 0) drain_pauses++;
         queue_op(i % 300 == 0, op, random_operand(), random_operand(), random_exponent());
      end
      total_items = pending_ops.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || expected_residues.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d transactions: add %0d, sub %0d, mul %0d, div %0d, pow %0d, unused %0d",
               accepted_items, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
               op_count[OP_DIV], op_count[OP_POW],
               op_count[OP_RSVD5] + op_count[OP_RSVD6] + op_count[OP_RSVD7]);
      $display("three stall profiles, %0d full drains, %0d mismatches", drain_pauses, mismatches);
      if (mismatches == 0 && expected_residues.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
